FILE: hdl/pbcp_pkg.sv
// Shared types, codes and constants of the PWM beep and clip player.
package pbcp_pkg;

    localparam int ActionWidth = 3;
    localparam int CountWidth = 17;
    localparam int RepWidth = 8;
    localparam int SectorWidth = 8;
    localparam int WordWidth = 16;
    localparam int QueueDepth = 4;
    localparam int QueuePtrWidth = $clog2(QueueDepth);

    localparam logic [ActionWidth-1:0] ACT_TICK = 3'd0;
    localparam logic [ActionWidth-1:0] ACT_BEEP = 3'd1;
    localparam logic [ActionWidth-1:0] ACT_CLIP = 3'd2;
    localparam logic [ActionWidth-1:0] ACT_STOP = 3'd3;
    localparam logic [ActionWidth-1:0] ACT_END_REP = 3'd4;

    localparam logic [0:0] CFG_END_TOKEN = 1'b0;
    localparam logic [0:0] CFG_BASE_OFFSET = 1'b1;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_BEEP = 2'd1;
    localparam logic [1:0] MODE_CLIP = 2'd2;

    localparam logic [WordWidth-1:0] LEVEL_SILENCE = 16'h0100;
    localparam logic [CountWidth-1:0] BEEP_TICKS_PER_REP = 17'd300;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_BEEP,
        CMD_CLIP,
        CMD_STOP,
        CMD_END_REP,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic [CountWidth-1:0] beep_ticks;
        logic [RepWidth-1:0] repetitions;
        logic [SectorWidth-1:0] start_sector;
        logic [WordWidth-1:0] start_offset;
        logic [WordWidth-1:0] sample_word;
        logic [WordWidth-1:0] restart_word;
    } cmd_t;

    function automatic logic [WordWidth-1:0] amp_level(input logic [1:0] idx);
        logic [WordWidth-1:0] lvl;
        case (idx)
            2'd0: lvl = 16'd256;
            2'd1: lvl = 16'd306;
            2'd2: lvl = 16'd256;
            2'd3: lvl = 16'd206;
            default: lvl = 16'd256;
        endcase
        return lvl;
    endfunction

endpackage

FILE: hdl/pbcp_front.sv
// Front end: decodes the action of an input beat into a command and precomputes the beep count.
module pbcp_front
    import pbcp_pkg::*;
(
    input  logic [ActionWidth-1:0] action,
    input  logic [RepWidth-1:0]    repetitions,
    input  logic [SectorWidth-1:0] start_sector,
    input  logic [WordWidth-1:0]   start_offset,
    input  logic [WordWidth-1:0]   sample_word,
    input  logic [WordWidth-1:0]   restart_word,
    output cmd_t                   cmd
);

    logic [RepWidth:0] rep_plus_one;

    assign rep_plus_one = {1'b0, repetitions} + {{RepWidth{1'b0}}, 1'b1};

    always_comb
    begin
        case (action)
            ACT_TICK: cmd.kind = CMD_TICK;
            ACT_BEEP: cmd.kind = CMD_BEEP;
            ACT_CLIP: cmd.kind = CMD_CLIP;
            ACT_STOP: cmd.kind = CMD_STOP;
            ACT_END_REP: cmd.kind = CMD_END_REP;
            default: cmd.kind = CMD_NOP;
        endcase
        cmd.beep_ticks = CountWidth'(BEEP_TICKS_PER_REP * CountWidth'(rep_plus_one));
        cmd.repetitions = repetitions;
        cmd.start_sector = start_sector;
        cmd.start_offset = start_offset;
        cmd.sample_word = sample_word;
        cmd.restart_word = restart_word;
    end

endmodule

FILE: hdl/pbcp_queue.sv
// Short command queue between the front end and the playback engine.
module pbcp_queue
    import pbcp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_cmd
);

    cmd_t entry_reg [QueueDepth];
    logic [QueuePtrWidth-1:0] wr_ptr_reg;
    logic [QueuePtrWidth-1:0] wr_ptr_next;
    logic [QueuePtrWidth-1:0] rd_ptr_reg;
    logic [QueuePtrWidth-1:0] rd_ptr_next;
    logic [QueuePtrWidth:0] count_reg;
    logic [QueuePtrWidth:0] count_next;

    assign full = (count_reg == (QueuePtrWidth+1)'(QueueDepth));
    assign not_empty = (count_reg != '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/pbcp_back.sv
// Playback engine: executes one queued command per beat and holds the result registers.
module pbcp_back
    import pbcp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [0:0]             cfg_index,
    input  logic [WordWidth-1:0]   cfg_data,
    input  logic                   cmd_valid,
    input  cmd_t                   cmd,
    output logic                   cmd_pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [WordWidth-1:0]   pwm_level,
    output logic                   amp_enabled,
    output logic [1:0]             mode,
    output logic [SectorWidth-1:0] read_sector,
    output logic [WordWidth-1:0]   read_offset
);

    logic [WordWidth-1:0] end_token_reg;
    logic [WordWidth-1:0] base_offset_reg;

    logic [CountWidth-1:0]  beep_left_reg;
    logic [CountWidth-1:0]  beep_left_next;
    logic [1:0]             table_idx_reg;
    logic [1:0]             table_idx_next;
    logic                   clip_active_reg;
    logic                   clip_active_next;
    logic [SectorWidth-1:0] cur_sector_reg;
    logic [SectorWidth-1:0] cur_sector_next;
    logic [WordWidth-1:0]   cur_offset_reg;
    logic [WordWidth-1:0]   cur_offset_next;
    logic [SectorWidth-1:0] restart_sector_reg;
    logic [SectorWidth-1:0] restart_sector_next;
    logic [WordWidth-1:0]   restart_offset_reg;
    logic [WordWidth-1:0]   restart_offset_next;
    logic [RepWidth-1:0]    repeats_left_reg;
    logic [RepWidth-1:0]    repeats_left_next;
    logic                   amp_on_reg;
    logic                   amp_on_next;
    logic [WordWidth-1:0]   level_reg;
    logic [WordWidth-1:0]   level_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic [SectorWidth-1:0] pos_sector;
    logic [WordWidth-1:0]   pos_offset;
    logic [WordWidth-1:0]   inc_offset;
    logic [WordWidth-1:0]   word_val;
    logic                   silence;
    logic                   advance;

    assign cmd_pop = cmd_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        beep_left_next = beep_left_reg;
        table_idx_next = table_idx_reg;
        clip_active_next = clip_active_reg;
        cur_sector_next = cur_sector_reg;
        cur_offset_next = cur_offset_reg;
        restart_sector_next = restart_sector_reg;
        restart_offset_next = restart_offset_reg;
        repeats_left_next = repeats_left_reg;
        amp_on_next = amp_on_reg;
        level_next = level_reg;
        silence = 1'b0;
        advance = 1'b0;
        pos_sector = cur_sector_reg;
        pos_offset = cur_offset_reg;
        word_val = cmd.sample_word;

        case (cmd.kind)
            CMD_TICK:
            begin
                if (beep_left_reg != '0)
                begin
                    beep_left_next = beep_left_reg - 1'b1;
                    level_next = amp_level(table_idx_reg);
                    table_idx_next = table_idx_reg + 1'b1;
                end
                else if (clip_active_reg)
                begin
                    if (cmd.sample_word == end_token_reg)
                    begin
                        if (repeats_left_reg != '0)
                        begin
                            repeats_left_next = repeats_left_reg - 1'b1;
                            pos_sector = restart_sector_reg;
                            pos_offset = restart_offset_reg;
                            word_val = cmd.restart_word;
                            advance = 1'b1;
                        end
                        else
                        begin
                            silence = 1'b1;
                        end
                    end
                    else
                    begin
                        advance = 1'b1;
                    end
                end
                else
                begin
                    silence = 1'b1;
                end
            end
            CMD_BEEP:
            begin
                beep_left_next = cmd.beep_ticks;
                clip_active_next = 1'b0;
                table_idx_next = '0;
                level_next = LEVEL_SILENCE;
                amp_on_next = 1'b1;
            end
            CMD_CLIP:
            begin
                beep_left_next = '0;
                cur_sector_next = cmd.start_sector;
                restart_sector_next = cmd.start_sector;
                cur_offset_next = cmd.start_offset;
                restart_offset_next = cmd.start_offset;
                level_next = LEVEL_SILENCE;
                clip_active_next = 1'b1;
                amp_on_next = 1'b1;
                repeats_left_next = cmd.repetitions;
            end
            CMD_STOP:
            begin
                silence = 1'b1;
            end
            CMD_END_REP:
            begin
                repeats_left_next = '0;
            end
            default:
            begin
            end
        endcase

        inc_offset = pos_offset + 1'b1;
        if (advance)
        begin
            level_next = word_val;
            if (inc_offset == '0)
            begin
                cur_offset_next = base_offset_reg;
                cur_sector_next = pos_sector + 1'b1;
            end
            else
            begin
                cur_offset_next = inc_offset;
                cur_sector_next = pos_sector;
            end
        end

        if (silence)
        begin
            amp_on_next = 1'b0;
            beep_left_next = '0;
            clip_active_next = 1'b0;
            repeats_left_next = '0;
        end

        if (cmd_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_token_reg <= 16'hffff;
            base_offset_reg <= '0;
            beep_left_reg <= '0;
            table_idx_reg <= '0;
            clip_active_reg <= 1'b0;
            cur_sector_reg <= '0;
            cur_offset_reg <= '0;
            restart_sector_reg <= '0;
            restart_offset_reg <= '0;
            repeats_left_reg <= '0;
            amp_on_reg <= 1'b0;
            level_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_END_TOKEN: end_token_reg <= cfg_data;
                    CFG_BASE_OFFSET: base_offset_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd_pop)
            begin
                beep_left_reg <= beep_left_next;
                table_idx_reg <= table_idx_next;
                clip_active_reg <= clip_active_next;
                cur_sector_reg <= cur_sector_next;
                cur_offset_reg <= cur_offset_next;
                restart_sector_reg <= restart_sector_next;
                restart_offset_reg <= restart_offset_next;
                repeats_left_reg <= repeats_left_next;
                amp_on_reg <= amp_on_next;
                level_reg <= level_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        if (beep_left_reg != '0)
        begin
            mode = MODE_BEEP;
        end
        else if (clip_active_reg)
        begin
            mode = MODE_CLIP;
        end
        else
        begin
            mode = MODE_IDLE;
        end
    end

    assign out_valid = out_valid_reg;
    assign pwm_level = level_reg;
    assign amp_enabled = amp_on_reg;
    assign read_sector = cur_sector_reg;
    assign read_offset = cur_offset_reg;

endmodule

FILE: hdl/pwm_beep_and_clip_player_core.sv
// Top level of the PWM beep and clip player: front end, command queue and playback engine.
// Every input beat (a PWM period tick or a command) yields exactly one output beat with the
// level for the PWM compare register, the amplifier enable, the mode and the flash position
// that the next tick must bring. Throughput is one beat per clock unless an output stall holds
// the flow: the front end decodes a beat into a four-entry command queue in the cycle it is
// accepted, and the playback engine executes one queued command per cycle into its result
// registers unless the output stalls. A beat passes the queue entry, then the result
// registers; input stall rises only when the queue is full.
module pwm_beep_and_clip_player_core
    import pbcp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [0:0]             cfg_index,
    input  logic [WordWidth-1:0]   cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [ActionWidth-1:0] action,
    input  logic [RepWidth-1:0]    repetitions,
    input  logic [SectorWidth-1:0] start_sector,
    input  logic [WordWidth-1:0]   start_offset,
    input  logic [WordWidth-1:0]   sample_word,
    input  logic [WordWidth-1:0]   restart_word,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [WordWidth-1:0]   pwm_level,
    output logic                   amp_enabled,
    output logic [1:0]             mode,
    output logic [SectorWidth-1:0] read_sector,
    output logic [WordWidth-1:0]   read_offset
);

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic queue_full;
    logic queue_not_empty;
    logic queue_pop;

    assign in_stall = queue_full;

    pbcp_front u_front (
        .action       (action),
        .repetitions  (repetitions),
        .start_sector (start_sector),
        .start_offset (start_offset),
        .sample_word  (sample_word),
        .restart_word (restart_word),
        .cmd          (front_cmd)
    );

    pbcp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !queue_full),
        .push_cmd  (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_cmd   (queue_cmd)
    );

    pbcp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd_valid   (queue_not_empty),
        .cmd         (queue_cmd),
        .cmd_pop     (queue_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pwm_level   (pwm_level),
        .amp_enabled (amp_enabled),
        .mode        (mode),
        .read_sector (read_sector),
        .read_offset (read_offset)
    );

endmodule

FILE: tb/pwm_beep_and_clip_player_core_tb.sv
// Testbench for the PWM beep and clip player core, with a directed table and random phases.
module pwm_beep_and_clip_player_core_tb;
    import pbcp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned BEATS_PER_PHASE = 280;
    localparam int NUM_ROWS = 24;
    localparam logic [ActionWidth-1:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [ActionWidth-1:0] ACT_UNUSED_HI = 3'd7;
    localparam logic [3:0][WordWidth-1:0] AMP_STEPS = {16'd206, 16'd256, 16'd306, 16'd256};

    typedef struct packed {
        logic [ActionWidth-1:0] act;
        logic [RepWidth-1:0]    reps;
        logic [SectorWidth-1:0] sector;
        logic [WordWidth-1:0]   offset;
        logic [WordWidth-1:0]   sample;
        logic [WordWidth-1:0]   restart;
    } player_beat_t;

    typedef struct packed {
        logic [WordWidth-1:0]   level;
        logic                   amp;
        logic [1:0]             mode;
        logic [SectorWidth-1:0] sector;
        logic [WordWidth-1:0]   offset;
    } player_out_t;

    typedef struct packed {
        player_beat_t    beat;
        logic [15:0]     count;
        logic            pinned;
        player_out_t     want;
    } directed_row_t;

    localparam player_out_t NO_PIN = '0;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [0:0]             cfg_index = CFG_END_TOKEN;
    logic [WordWidth-1:0]   cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [ActionWidth-1:0] action = ACT_TICK;
    logic [RepWidth-1:0]    repetitions = '0;
    logic [SectorWidth-1:0] start_sector = '0;
    logic [WordWidth-1:0]   start_offset = '0;
    logic [WordWidth-1:0]   sample_word = '0;
    logic [WordWidth-1:0]   restart_word = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [WordWidth-1:0]   pwm_level;
    logic                   amp_enabled;
    logic [1:0]             mode;
    logic [SectorWidth-1:0] read_sector;
    logic [WordWidth-1:0]   read_offset;

    pwm_beep_and_clip_player_core DUT (.*);

    logic [CountWidth-1:0]  tone_ticks_left;
    logic [1:0]             step_idx;
    logic                   clip_on;
    logic [SectorWidth-1:0] play_sector;
    logic [WordWidth-1:0]   play_offset;
    logic [SectorWidth-1:0] loop_sector;
    logic [WordWidth-1:0]   loop_offset;
    logic [RepWidth-1:0]    loops_left;
    logic                   amp_live;
    logic [WordWidth-1:0]   level_now;
    logic [WordWidth-1:0]   end_word;
    logic [WordWidth-1:0]   wrap_offset;

    player_out_t due_outputs[$];
    int unsigned beats_sent = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;

    directed_row_t script [NUM_ROWS] = '{
        {ACT_TICK, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'd1, 1'b1,
            {16'h0000, 1'b0, MODE_IDLE, 8'h00, 16'h0000}},
        {ACT_UNUSED_HI, 8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'd1, 1'b1,
            {16'h0000, 1'b0, MODE_IDLE, 8'h00, 16'h0000}},
        {ACT_BEEP, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'd1, 1'b1,
            {LEVEL_SILENCE, 1'b1, MODE_BEEP, 8'h00, 16'h0000}},
        {ACT_TICK, 8'h5a, 8'ha5, 16'h1234, 16'h4321, 16'h8765, 16'd2, 1'b0, NO_PIN},
        {ACT_STOP, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'd1, 1'b0, NO_PIN},
        {ACT_BEEP, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'd1, 1'b0, NO_PIN},
        {ACT_TICK, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'd300, 1'b0, NO_PIN},
        {ACT_TICK, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'd1, 1'b0, NO_PIN},
        {ACT_BEEP, 8'hff, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'd1, 1'b1,
            {LEVEL_SILENCE, 1'b1, MODE_BEEP, 8'h00, 16'h0000}},
        {ACT_TICK, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'd3, 1'b0, NO_PIN},
        {ACT_CLIP, 8'h01, 8'hff, 16'hfffe, 16'h0000, 16'h0000, 16'd1, 1'b1,
            {LEVEL_SILENCE, 1'b1, MODE_CLIP, 8'hff, 16'hfffe}},
        {ACT_TICK, 8'h00, 8'h00, 16'h0000, 16'h1234, 16'h0000, 16'd1, 1'b0, NO_PIN},
        {ACT_TICK, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'd1, 1'b0, NO_PIN},
        {ACT_TICK, 8'h00, 8'h00, 16'h0000, 16'hffff, 16'habcd, 16'd1, 1'b0, NO_PIN},
        {ACT_TICK, 8'h00, 8'h00, 16'h0000, 16'hffff, 16'h0000, 16'd1, 1'b0, NO_PIN},
        {ACT_CLIP, 8'hff, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'd1, 1'b1,
            {LEVEL_SILENCE, 1'b1, MODE_CLIP, 8'h00, 16'h0000}},
        {ACT_TICK, 8'h00, 8'h00, 16'h0000, 16'hffff, 16'hffff, 16'd1, 1'b0, NO_PIN},
        {ACT_BEEP, 8'h05, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'd1, 1'b0, NO_PIN},
        {ACT_STOP, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'd1, 1'b0, NO_PIN},
        {ACT_CLIP, 8'hc8, 8'h80, 16'h7fff, 16'h0000, 16'h0000, 16'd1, 1'b0, NO_PIN},
        {ACT_TICK, 8'h00, 8'h00, 16'h0000, 16'h5555, 16'h0000, 16'd1, 1'b0, NO_PIN},
        {ACT_END_REP, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'd1, 1'b0, NO_PIN},
        {ACT_TICK, 8'h00, 8'h00, 16'h0000, 16'hffff, 16'h0000, 16'd1, 1'b0, NO_PIN},
        {ACT_UNUSED_LO, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'd1, 1'b0, NO_PIN}
    };

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("pwm_beep_and_clip_player_core verification failed");
            $finish;
        end
    end

    function automatic void mute_player();
        amp_live = 1'b0;
        tone_ticks_left = '0;
        clip_on = 1'b0;
        loops_left = '0;
    endfunction

    function automatic player_out_t advance_player(input player_beat_t b);
        player_out_t r;
        logic [WordWidth-1:0] word;
        case (b.act)
            ACT_TICK:
            begin
                if (tone_ticks_left != '0)
                begin
                    tone_ticks_left = tone_ticks_left - 1'b1;
                    level_now = AMP_STEPS[step_idx];
                    step_idx = step_idx + 1'b1;
                end
                else if (!clip_on)
                begin
                    mute_player();
                end
                else if (b.sample == end_word && loops_left == '0)
                begin
                    mute_player();
                end
                else
                begin
                    word = b.sample;
                    if (b.sample == end_word)
                    begin
                        loops_left = loops_left - 1'b1;
                        play_sector = loop_sector;
                        play_offset = loop_offset;
                        word = b.restart;
                    end
                    level_now = word;
                    play_offset = play_offset + 1'b1;
                    if (play_offset == '0)
                    begin
                        play_offset = wrap_offset;
                        play_sector = play_sector + 1'b1;
                    end
                end
            end
            ACT_BEEP:
            begin
                tone_ticks_left = BEEP_TICKS_PER_REP * ({9'd0, b.reps} + 17'd1);
                clip_on = 1'b0;
                step_idx = '0;
                level_now = LEVEL_SILENCE;
                amp_live = 1'b1;
            end
            ACT_CLIP:
            begin
                tone_ticks_left = '0;
                play_sector = b.sector;
                loop_sector = b.sector;
                play_offset = b.offset;
                loop_offset = b.offset;
                level_now = LEVEL_SILENCE;
                clip_on = 1'b1;
                amp_live = 1'b1;
                loops_left = b.reps;
            end
            ACT_STOP: mute_player();
            ACT_END_REP: loops_left = '0;
            default: ;
        endcase
        r.level = level_now;
        r.amp = amp_live;
        r.mode = (tone_ticks_left != '0) ? MODE_BEEP : (clip_on ? MODE_CLIP : MODE_IDLE);
        r.sector = play_sector;
        r.offset = play_offset;
        return r;
    endfunction

    function automatic player_beat_t random_beat(input logic [ActionWidth-1:0] act);
        player_beat_t b;
        logic [31:0] r1;
        logic [31:0] r2;
        r1 = $urandom;
        r2 = $urandom;
        b.act = act;
        b.reps = r1[7:0];
        b.sector = r1[15:8];
        b.offset = r1[31:16];
        b.sample = r2[15:0];
        b.restart = r2[31:16];
        return b;
    endfunction

    task automatic send_beat(input player_beat_t b, input logic pinned, input player_out_t want);
        player_out_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= b.act;
        repetitions <= b.reps;
        start_sector <= b.sector;
        start_offset <= b.offset;
        sample_word <= b.sample;
        restart_word <= b.restart;
        do @(posedge clk); while (in_stall);
        predicted = advance_player(b);
        due_outputs.push_back(pinned ? want : predicted);
        beats_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (due_outputs.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [WordWidth-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_END_TOKEN)
            end_word = val;
        else
            wrap_offset = val;
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned stop_at;
        int unsigned len;
        int unsigned pick;
        int unsigned k;
        player_beat_t b;
        stop_at = beats_sent + n;
        while (beats_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                b = random_beat(ACT_CLIP);
                if ($urandom_range(2) == 0)
                    b.offset = 16'($urandom_range(16'hffff, 16'hfff0));
                if ($urandom_range(7) != 0)
                    b.reps = 8'($urandom_range(3));
                send_beat(b, 1'b0, NO_PIN);
                len = $urandom_range(40, 1);
                for (k = 0; k < len; k++)
                begin
                    pick = $urandom_range(59);
                    if (pick == 0)
                    begin
                        b = random_beat(ACT_END_REP);
                    end
                    else if (pick == 1)
                    begin
                        b = random_beat(ACT_STOP);
                    end
                    else
                    begin
                        b = random_beat(ACT_TICK);
                        if (pick < 10)
                            b.sample = end_word;
                    end
                    send_beat(b, 1'b0, NO_PIN);
                end
            end
            else if (pick < 80)
            begin
                b = random_beat(ACT_BEEP);
                if ($urandom_range(14) == 0)
                begin
                    b.reps = '0;
                    len = 300 + $urandom_range(4, 1);
                end
                else
                begin
                    if ($urandom_range(7) != 0)
                        b.reps = 8'($urandom_range(2));
                    len = $urandom_range(24, 1);
                end
                send_beat(b, 1'b0, NO_PIN);
                for (k = 0; k < len; k++)
                    send_beat(random_beat(ACT_TICK), 1'b0, NO_PIN);
            end
            else
            begin
                len = $urandom_range(6, 1);
                for (k = 0; k < len; k++)
                    send_beat(random_beat(3'($urandom_range(ACT_UNUSED_HI))), 1'b0, NO_PIN);
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        player_out_t want;
        player_out_t got;
        out_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            got = {pwm_level, amp_enabled, mode, read_sector, read_offset};
            if (due_outputs.size() == 0)
            begin
                if (mismatches < 10)
                    $display({"unexpected output beat: ",
                              "level=%h amp=%b mode=%h sector=%h offset=%h"},
                             got.level, got.amp, got.mode, got.sector, got.offset);
                mismatches++;
            end
            else
            begin
                want = due_outputs.pop_front();
                if (got.level !== want.level || got.amp !== want.amp || got.mode !== want.mode
                        || got.sector !== want.sector || got.offset !== want.offset)
                begin
                    if (mismatches < 10)
                        $display({"mismatch: expected level=%h amp=%b mode=%h sector=%h ",
                                  "offset=%h, got level=%h amp=%b mode=%h sector=%h offset=%h"},
                                 want.level, want.amp, want.mode, want.sector, want.offset,
                                 got.level, got.amp, got.mode, got.sector, got.offset);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned row;
        int unsigned k;
        int unsigned phase;
        tone_ticks_left = '0;
        step_idx = '0;
        clip_on = 1'b0;
        play_sector = '0;
        play_offset = '0;
        loop_sector = '0;
        loop_offset = '0;
        loops_left = '0;
        amp_live = 1'b0;
        level_now = '0;
        end_word = 16'hffff;
        wrap_offset = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < NUM_ROWS; row++)
            for (k = 0; k < script[row].count; k++)
                send_beat(script[row].beat, script[row].pinned, script[row].want);
        settle();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                    write_reg(CFG_END_TOKEN, 16'hffff);
                    write_reg(CFG_BASE_OFFSET, 16'h0000);
                end
                1:
                begin
                    idle_pct = 58;
                    stall_pct = 0;
                    write_reg(CFG_END_TOKEN, 16'h0000);
                    write_reg(CFG_BASE_OFFSET, 16'hffff);
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 58;
                    write_reg(CFG_END_TOKEN, 16'($urandom));
                    write_reg(CFG_BASE_OFFSET, 16'($urandom));
                end
                default:
                begin
                    idle_pct = 11;
                    stall_pct = 11;
                    write_reg(CFG_END_TOKEN, 16'h8000);
                    write_reg(CFG_BASE_OFFSET, 16'hfff0);
                end
            endcase
            run_random(BEATS_PER_PHASE);
            settle();
        end

        if (mismatches == 0 && due_outputs.size() == 0)
            $display("pwm_beep_and_clip_player_core verification clean");
        else
            $display("pwm_beep_and_clip_player_core verification failed");
        $finish;
    end

endmodule
